[hw/rtl/far_pkg.sv]
`default_nettype none

package far_pkg;

    // Field width of the numerator and denominator on the ports
    localparam int DATA_W = 32;

    // Default accumulator width
    localparam int WIDTH_DEFAULT = 32;

    // Multiplier bits retired per cycle by the shift-add multipliers
    localparam int MUL_DIGIT = 8;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_ADD  = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic signed [DATA_W-1:0] in_numerator;
        logic signed [DATA_W-1:0] in_denominator;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_numerator;
        logic signed [DATA_W-1:0] out_denominator;
    } result_t;

    // Controller -> datapath
    typedef struct packed {
        logic capture;     // take the item, seed the multipliers
        logic mul_step;    // retire one multiplier digit
        logic sum_load;    // form new n, d and seed the gcd
        logic gcd_step;    // one binary gcd step
        logic gcd_finish;  // restore common power of two, seed the dividers
        logic div_step;    // one quotient bit
        logic commit;      // update accumulator and result register
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic both_pos;    // new n and d both strictly positive
        logic gcd_equal;   // gcd operands have met
    } status_t;

endpackage

`default_nettype wire

[hw/rtl/far_ctrl.sv]
`default_nettype none

module far_ctrl #(
    parameter int WIDTH = far_pkg::WIDTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  wire logic            item_kind,
    output logic                 item_stall,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output far_pkg::cmd_t        cmd,
    input  wire far_pkg::status_t status
);

    localparam int MUL_STEPS = (WIDTH + far_pkg::MUL_DIGIT - 1) / far_pkg::MUL_DIGIT;
    localparam int CNT_W     = $clog2(WIDTH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_SUM  = 6'b000100,
        S_GCD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = (item_kind == far_pkg::KIND_ADD) ? S_MUL : S_FIN;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SUM:
            begin
                cmd.sum_load = 1'b1;
                state_next   = S_GCD;
            end
            S_GCD:
            begin
                if (!status.both_pos)
                begin
                    state_next = S_FIN;   // zero or negative part: stored as is
                end
                else if (status.gcd_equal)
                begin
                    cmd.gcd_finish = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    // one word in flight: after an accept the input stays closed
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("item accepted while another word is in flight");

    // result only appears from a commit
    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(cmd.commit))
        else $error("result valid without commit");

    // gcd only runs on positive operands
    a_gcd_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.gcd_step || cmd.gcd_finish) |-> status.both_pos)
        else $error("gcd run on non-positive fraction");

    // a commit never overwrites an untaken result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!result_valid || !result_stall))
        else $error("result overwritten");

endmodule

`default_nettype wire

[hw/rtl/far_datapath.sv]
`default_nettype none

module far_datapath #(
    parameter int WIDTH = far_pkg::WIDTH_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire far_pkg::item_t  item,
    input  wire far_pkg::cmd_t   cmd,
    output far_pkg::status_t     status,
    output far_pkg::result_t     result
);

    localparam int K_W = $clog2(WIDTH);

    // accumulator
    logic [WIDTH-1:0] acc_n_reg, acc_d_reg;

    // working fraction; doubles as the dividend / quotient shift registers
    logic [WIDTH-1:0] n_reg, d_reg;

    // three shift-add multiplier lanes: acc_n*xd, xn*acc_d, acc_d*xd
    logic [WIDTH-1:0] mcand_reg  [3];
    logic [WIDTH-1:0] mplier_reg [3];
    logic [WIDTH-1:0] prod_reg   [3];

    // binary gcd
    logic [WIDTH-1:0] ga_reg, gb_reg, ga_next, gb_next;
    logic [K_W-1:0]   gk_reg, gk_next;
    logic [WIDTH-1:0] g_reg;

    // divider remainders
    logic [WIDTH-1:0] rem_n_reg, rem_d_reg;

    far_pkg::result_t out_reg;

    logic [WIDTH-1:0] xn, xd, sum;
    logic [2*WIDTH-1:0] div_n, div_d;

    // one restoring-division step: returns {remainder, quotient}
    function automatic logic [2*WIDTH-1:0] div_step_f(
        input logic [WIDTH-1:0] rem,
        input logic [WIDTH-1:0] quo,
        input logic [WIDTH-1:0] dvs
    );
        logic [WIDTH-1:0] shifted;
        logic [WIDTH:0]   trial;
        // rem < dvs < 2^(WIDTH-1), so its top bit is always clear
        shifted = {rem[WIDTH-2:0], quo[WIDTH-1]};
        trial   = {1'b0, shifted} - {1'b0, dvs};
        if (!trial[WIDTH])
        begin
            return {trial[WIDTH-1:0], quo[WIDTH-2:0], 1'b1};
        end
        return {shifted, quo[WIDTH-2:0], 1'b0};
    endfunction

    assign xn    = WIDTH'($unsigned(item.in_numerator));
    assign xd    = WIDTH'($unsigned(item.in_denominator));
    assign sum   = prod_reg[0] + prod_reg[1];
    assign div_n = div_step_f(rem_n_reg, n_reg, g_reg);
    assign div_d = div_step_f(rem_d_reg, d_reg, g_reg);

    always_comb
    begin
        ga_next = ga_reg;
        gb_next = gb_reg;
        gk_next = gk_reg;
        if (!ga_reg[0] && !gb_reg[0])
        begin
            ga_next = ga_reg >> 1;
            gb_next = gb_reg >> 1;
            gk_next = gk_reg + 1'b1;
        end
        else if (!ga_reg[0])
        begin
            ga_next = ga_reg >> 1;
        end
        else if (!gb_reg[0])
        begin
            gb_next = gb_reg >> 1;
        end
        else if (ga_reg > gb_reg)
        begin
            ga_next = (ga_reg - gb_reg) >> 1;
        end
        else
        begin
            gb_next = (gb_reg - ga_reg) >> 1;
        end
    end

    assign status.both_pos  = (n_reg != '0) && !n_reg[WIDTH-1]
                           && (d_reg != '0) && !d_reg[WIDTH-1];
    assign status.gcd_equal = (ga_reg == gb_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            n_reg         <= xn;
            d_reg         <= xd;
            mcand_reg[0]  <= acc_n_reg;
            mplier_reg[0] <= xd;
            mcand_reg[1]  <= xn;
            mplier_reg[1] <= acc_d_reg;
            mcand_reg[2]  <= acc_d_reg;
            mplier_reg[2] <= xd;
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= '0;
            end
        end

        if (cmd.mul_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i]   <= prod_reg[i]
                               + WIDTH'(mcand_reg[i] * mplier_reg[i][far_pkg::MUL_DIGIT-1:0]);
                mcand_reg[i]  <= mcand_reg[i] << far_pkg::MUL_DIGIT;
                mplier_reg[i] <= mplier_reg[i] >> far_pkg::MUL_DIGIT;
            end
        end

        if (cmd.sum_load)
        begin
            n_reg  <= sum;
            d_reg  <= prod_reg[2];
            ga_reg <= sum;
            gb_reg <= prod_reg[2];
            gk_reg <= '0;
        end

        if (cmd.gcd_step)
        begin
            ga_reg <= ga_next;
            gb_reg <= gb_next;
            gk_reg <= gk_next;
        end

        if (cmd.gcd_finish)
        begin
            g_reg     <= ga_reg << gk_reg;
            rem_n_reg <= '0;
            rem_d_reg <= '0;
        end

        if (cmd.div_step)
        begin
            rem_n_reg <= div_n[2*WIDTH-1:WIDTH];
            n_reg     <= div_n[WIDTH-1:0];
            rem_d_reg <= div_d[2*WIDTH-1:WIDTH];
            d_reg     <= div_d[WIDTH-1:0];
        end

        if (cmd.commit)
        begin
            out_reg.out_numerator   <= far_pkg::DATA_W'(n_reg);
            out_reg.out_denominator <= far_pkg::DATA_W'(d_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_n_reg <= '0;
            acc_d_reg <= WIDTH'(1);
        end
        else if (cmd.commit)
        begin
            acc_n_reg <= n_reg;
            acc_d_reg <= d_reg;
        end
    end

    assign result = out_reg;

    // binary gcd keeps both operands nonzero
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gcd_step |=> (ga_reg != '0) && (gb_reg != '0))
        else $error("gcd operand reached zero");

    // divisor is never zero while dividing
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (g_reg != '0))
        else $error("division by zero gcd");

    // partial remainders stay below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_n_reg < g_reg) && (rem_d_reg < g_reg))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire

[hw/rtl/fraction_add_reduce_unit.sv]
`default_nettype none

// Channel   Word type          Handshake                 Direction
// item      far_pkg::item_t    item_valid / item_stall   into the unit
// result    far_pkg::result_t  result_valid / result_stall  out of the unit
//
// One word at a time. A load is captured and then goes straight to the commit. An add
// runs the capture, the shift-add multiply, the sum, the binary gcd loop, the restoring
// divide and the commit, in that order; the gcd loop and the dividers take most of its time.
// An add whose sum has a zero or negative part skips gcd and divide.
// Reset (rst_n low, async) clears the controller and sets the accumulator to 0/1.
// A stalled result holds the next commit, and no new word is accepted until that commit.

module fraction_add_reduce_unit #(
    parameter int WIDTH = far_pkg::WIDTH_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire far_pkg::item_t   item,
    input  wire logic             item_valid,
    output logic                  item_stall,

    output far_pkg::result_t      result,
    output logic                  result_valid,
    input  wire logic             result_stall
);

    // command and status between the sequencer and the arithmetic
    far_pkg::cmd_t    cmd;
    far_pkg::status_t status;

    // sequencer: multiply, sum, gcd, divide, commit
    far_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_kind    (item.kind),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cmd          (cmd),
        .status       (status)
    );

    // accumulator, shift-add multipliers, binary gcd, restoring dividers,
    // result register
    far_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

`default_nettype wire
